@@ src/servo_status_packet_checker_unit_macros.svh @@
// assertion helpers used by the frame check rtl
`ifndef SERVO_STATUS_PACKET_CHECKER_UNIT_MACROS_SVH
`define SERVO_STATUS_PACKET_CHECKER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SSPC_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("sspc assertion failed");

// next-cycle implication, disabled during reset
`define SSPC_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("sspc assertion failed");

`endif

@@ src/sspc_pkg.sv @@
`default_nettype none

package sspc_pkg;

  localparam int unsigned MAX_PAYLOAD = 250;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;

  // frame status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HEADER   = 3'd1;
  localparam logic [2:0] ST_ID       = 3'd2;
  localparam logic [2:0] ST_LENGTH   = 3'd3;
  localparam logic [2:0] ST_CHECKSUM = 3'd4;

  // register indexes
  localparam logic REG_MATCH_ID       = 1'b0;
  localparam logic REG_PAYLOAD_LENGTH = 1'b1;

  localparam logic [7:0] MATCH_ID_RESET       = 8'd1;
  localparam logic [7:0] PAYLOAD_LENGTH_RESET = 8'd2;

  // frame positions
  localparam logic [7:0] POS_ID     = 8'd2;
  localparam logic [7:0] POS_LENGTH = 8'd3;
  localparam logic [7:0] POS_ERROR  = 8'd4;
  localparam logic [8:0] PAYLOAD_START = 9'd5;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       last_of_frame;
    logic [2:0] frame_status;
    logic [7:0] servo_error;
  } result_t;

endpackage

`default_nettype wire

@@ src/sspc_ifs.sv @@
`default_nettype none

// received byte channel
interface sspc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// result channel
interface sspc_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_frame;
  logic [2:0] frame_status;
  logic [7:0] servo_error;

  modport source (output valid, output data_byte, output last_of_frame,
                  output frame_status, output servo_error, input ready);
  modport sink (input valid, input data_byte, input last_of_frame,
                input frame_status, input servo_error, output ready);
endinterface

`default_nettype wire

@@ src/sspc_frame_check.sv @@
`default_nettype none
`include "servo_status_packet_checker_unit_macros.svh"

module sspc_frame_check #(
  parameter int unsigned MaxPayload = sspc_pkg::MAX_PAYLOAD
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       rx_byte,
  input  wire logic [7:0]       match_id,
  input  wire logic [7:0]       payload_length,
  output sspc_pkg::result_t     result
);

  localparam logic [7:0] MaxLen = 8'(MaxPayload);

  logic [7:0] byte_position, byte_position_next;
  logic [7:0] running_sum, running_sum_next;
  logic [2:0] first_failure, first_failure_next;
  logic [7:0] error_byte, error_byte_next;

  logic [7:0] len;
  logic [8:0] csum_pos;
  logic       at_checksum;
  logic [7:0] sum_with_byte;
  logic       frame_clear;

  assign len         = (payload_length > MaxLen) ? MaxLen : payload_length;
  assign csum_pos    = sspc_pkg::PAYLOAD_START + {1'b0, len};
  assign at_checksum = {1'b0, byte_position} >= csum_pos;
  assign sum_with_byte = running_sum + rx_byte;
  assign frame_clear = byte_position == 8'd0 && running_sum == 8'd0 &&
                       first_failure == sspc_pkg::ST_OK;

  always_comb begin
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    first_failure_next = first_failure;
    error_byte_next    = error_byte;
    result             = '0;
    if (step) begin
      if (at_checksum) begin
        result.valid         = 1'b1;
        result.last_of_frame = 1'b1;
        result.servo_error   = error_byte;
        if (first_failure != sspc_pkg::ST_OK) begin
          result.frame_status = first_failure;
        end else if (rx_byte != ~running_sum) begin
          result.frame_status = sspc_pkg::ST_CHECKSUM;
        end else begin
          result.frame_status = sspc_pkg::ST_OK;
        end
        // re-arm for the next frame
        byte_position_next = '0;
        running_sum_next   = '0;
        first_failure_next = sspc_pkg::ST_OK;
        error_byte_next    = '0;
      end else begin
        byte_position_next = byte_position + 8'd1;
        if (byte_position < sspc_pkg::POS_ID) begin
          if (rx_byte != sspc_pkg::HEADER_BYTE && first_failure == sspc_pkg::ST_OK) begin
            first_failure_next = sspc_pkg::ST_HEADER;
          end
        end else begin
          running_sum_next = sum_with_byte;
          if (byte_position == sspc_pkg::POS_ID) begin
            if (rx_byte != match_id && first_failure == sspc_pkg::ST_OK) begin
              first_failure_next = sspc_pkg::ST_ID;
            end
          end else if (byte_position == sspc_pkg::POS_LENGTH) begin
            if (rx_byte != (len + 8'd2) && first_failure == sspc_pkg::ST_OK) begin
              first_failure_next = sspc_pkg::ST_LENGTH;
            end
          end else if (byte_position == sspc_pkg::POS_ERROR) begin
            error_byte_next = rx_byte;
          end else begin
            result.valid     = 1'b1;
            result.data_byte = rx_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_sum   <= '0;
      first_failure <= sspc_pkg::ST_OK;
      error_byte    <= '0;
    end else begin
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      first_failure <= first_failure_next;
      error_byte    <= error_byte_next;
    end
  end

  // a verdict leaves the frame state cleared
  `SSPC_ASSERT_NEXT(a_rearm, clk, rst, step && at_checksum, frame_clear)
  // a non-closing byte advances the position by one
  `SSPC_ASSERT_NEXT(a_advance, clk, rst, step && !at_checksum, byte_position == $past(byte_position) + 8'd1)
  // without a byte the frame state holds
  `SSPC_ASSERT_NEXT(a_hold, clk, rst, !step, $stable(byte_position) && $stable(running_sum) && $stable(first_failure))

endmodule

`default_nettype wire

@@ src/servo_status_packet_checker_unit.sv @@
// servo status reply checker
// rx channel: one received byte per transaction, in frame order, starting with
//   the two header bytes of a reply
// res channel: one transaction per payload byte (last_of_frame low, payload
//   in data_byte) and one verdict transaction on the checksum byte
//   (last_of_frame high, frame_status and servo_error set, data_byte zero)
// apb port: register 0 match id at byte address 0, register 1
//   payload_length at byte address 4; write only while no frame byte is in
//   flight; pready is always high
// flow: a byte is taken into the input register, checked from there and its
//   result is taken into the result register that drives res
// throughput: one byte per cycle while res is not stalled, set by the single input
//   register feeding the single result register; the input register can still take
//   one byte while a finished result waits to be taken
// receiver stall: the result register holds; the byte behind it waits in the
//   input register and rx ready drops only when both are full
// reset: synchronous, clears both stages, the frame state and loads the
//   register defaults (match id 1, payload_length 2)
`default_nettype none

module servo_status_packet_checker_unit #(
  parameter int unsigned MaxPayload = sspc_pkg::MAX_PAYLOAD
) (
  input  wire logic         clk,
  input  wire logic         rst,
  sspc_rx_if.sink           rx,
  sspc_res_if.source        res,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // configuration registers
  logic [7:0] match_id;
  logic [7:0] payload_length;
  logic       reg_sel;

  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_id       <= sspc_pkg::MATCH_ID_RESET;
      payload_length <= sspc_pkg::PAYLOAD_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (reg_sel == sspc_pkg::REG_MATCH_ID) begin
        match_id <= pwdata[7:0];
      end else begin
        payload_length <= pwdata[7:0];
      end
    end
  end

  assign prdata = (reg_sel == sspc_pkg::REG_PAYLOAD_LENGTH) ? {24'd0, payload_length}
                                                           : {24'd0, match_id};

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       step;
  logic       out_free;

  // result register can take a new transaction
  assign out_free = !res.valid || res.ready;
  // byte in the input register is checked and leaves this cycle
  assign step     = in_valid && out_free;
  assign rx.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  // per-byte frame check and frame state
  sspc_pkg::result_t check_result;

  sspc_frame_check #(
    .MaxPayload(MaxPayload)
  ) u_check (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .rx_byte        (in_byte),
    .match_id       (match_id),
    .payload_length (payload_length),
    .result         (check_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_free) begin
      res.valid <= check_result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && check_result.valid) begin
      res.data_byte     <= check_result.data_byte;
      res.last_of_frame <= check_result.last_of_frame;
      res.frame_status  <= check_result.frame_status;
      res.servo_error   <= check_result.servo_error;
    end
  end

endmodule

`default_nettype wire
